@@ src/cra_pkg.sv @@
// shared types, constants and codes for the contiguous run bitmap allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cra_pkg;

  localparam int SECTOR_BYTES_DEF    = 512;
  localparam int MAX_MAP_SECTORS_DEF = 4;

  localparam int WORD_W   = 32;
  localparam int WBIT_W   = 5;
  localparam int COUNT_W  = 15;
  localparam int WIDX_W   = 9;
  localparam int FDS_W    = 24;
  localparam int MSEC_W   = 3;
  localparam int FSEC_W   = 25;

  localparam int DIGIT_W  = 8;
  localparam int DIGIT_IW = 3;
  localparam int DIG_CNT_W = 2;
  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(WORD_W / DIGIT_W - 1);

  localparam logic [MSEC_W-1:0] MSEC_RESET = MSEC_W'(1);

  typedef enum logic {
    REQ_ALLOC  = 1'b0,
    REQ_PRESET = 1'b1
  } req_t;

  typedef enum logic {
    CFG_FIRST_DATA_SECTOR = 1'b0,
    CFG_MAP_SECTORS       = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic from_mem;
  } scan_ctl_t;

endpackage

`default_nettype wire

@@ src/cra_in_if.sv @@
// request channel: valid/ready handshake with one allocate or preset request
// depends on cra_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cra_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [cra_pkg::COUNT_W-1:0]   sector_count;
  logic [cra_pkg::WIDX_W-1:0]    word_index;
  logic [cra_pkg::WORD_W-1:0]    word_value;

  modport source (output valid, req_type, sector_count, word_index, word_value,
                  input ready);
  modport sink   (input valid, req_type, sector_count, word_index, word_value,
                  output ready);
endinterface

`default_nettype wire

@@ src/cra_out_if.sv @@
// result channel: valid/ready handshake with one allocation or preset result
// depends on cra_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cra_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [cra_pkg::FSEC_W-1:0]    first_sector;
  logic [cra_pkg::COUNT_W-1:0]   granted_count;
  logic                          fell_back;

  modport source (output valid, ok, first_sector, granted_count, fell_back,
                  input ready);
  modport sink   (input valid, ok, first_sector, granted_count, fell_back,
                  output ready);
endinterface

`default_nettype wire

@@ src/cra_map.sv @@
// sector bitmap storage: one write port, one read port with registered data
// depends on cra_pkg
`timescale 1ns / 1ps
`default_nettype none

module cra_map #(
  parameter int WORDS = 512,
  parameter int AW    = 9
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [cra_pkg::WORD_W-1:0]  wdata,
  input  wire logic [AW-1:0]               raddr,
  output      logic [cra_pkg::WORD_W-1:0]  rdata_r
);

  logic [cra_pkg::WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/cra_digit_scan.sv @@
// run finder: shifts a map word through eight bits a cycle while step is set, tracks the
// current clear run and flags the earliest bit at which it reaches the length
// depends on cra_pkg
`timescale 1ns / 1ps
`default_nettype none

module cra_digit_scan #(
  parameter int BW = 14
) (
  input  wire logic                         clk,
  input  wire cra_pkg::scan_ctl_t           ctl,
  input  wire logic [cra_pkg::WORD_W-1:0]   rdata,
  input  wire logic [BW-1:0]                base,
  input  wire logic [cra_pkg::COUNT_W-1:0]  len,
  output      logic                         hit,
  output      logic [BW-1:0]                hit_start
);

  logic [cra_pkg::WORD_W-1:0]    sh_r;
  logic [cra_pkg::COUNT_W-1:0]   run_r;
  logic [BW-1:0]                 first_r;

  logic [cra_pkg::DIGIT_W-1:0]   digit;
  logic [cra_pkg::WORD_W-1:0]    sh_src;
  logic                          seen;
  logic [cra_pkg::DIGIT_IW-1:0]  lastp;
  logic [cra_pkg::COUNT_W:0]     runk;
  logic [BW-1:0]                 stk;
  logic                          found;
  logic [cra_pkg::COUNT_W-1:0]   run_nxt;
  logic [BW-1:0]                 first_nxt;

  assign sh_src = ctl.from_mem ? rdata : sh_r;
  assign digit  = sh_src[cra_pkg::DIGIT_W-1:0];

  always_comb begin
    seen      = 1'b0;
    lastp     = '0;
    found     = 1'b0;
    hit_start = '0;
    runk      = '0;
    stk       = '0;
    for (int k = 0; k < cra_pkg::DIGIT_W; k++) begin
      if (digit[k]) begin
        seen  = 1'b1;
        lastp = cra_pkg::DIGIT_IW'(k);
      end
      if (seen) begin
        runk = (cra_pkg::COUNT_W+1)'(cra_pkg::DIGIT_IW'(k) - lastp);
        stk  = base + BW'(lastp) + BW'(1);
      end else begin
        runk = (cra_pkg::COUNT_W+1)'(run_r) + (cra_pkg::COUNT_W+1)'(k + 1);
        stk  = (run_r == '0) ? base : first_r;
      end
      if (!digit[k] && !found && runk == (cra_pkg::COUNT_W+1)'(len)) begin
        found     = 1'b1;
        hit_start = stk;
      end
    end
    if (seen) begin
      run_nxt   = cra_pkg::COUNT_W'(cra_pkg::DIGIT_IW'(cra_pkg::DIGIT_W - 1) - lastp);
      first_nxt = base + BW'(lastp) + BW'(1);
    end else begin
      run_nxt   = run_r + cra_pkg::COUNT_W'(cra_pkg::DIGIT_W);
      first_nxt = (run_r == '0) ? base : first_r;
    end
  end

  assign hit = ctl.step && found;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      run_r   <= '0;
      first_r <= '0;
    end else if (ctl.step) begin
      sh_r    <= sh_src >> cra_pkg::DIGIT_W;
      run_r   <= run_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/contiguous_run_bitmap_allocator.sv @@
// First-fit contiguous sector allocator over a bitmap memory of
// MAX_MAP_SECTORS*SECTOR_BYTES/4 words (set bit = used). After reset a clearing
// pass zeroes the map, one word a cycle, with the request channel held off.
// A preset writes its word on acceptance and goes straight to the response.
// An allocate scans the searched words eight bits a cycle, after a fetch step
// that clears the run finder, for each attempt of the halving sequence (up to
// log2(count)+1 attempts), then marks the granted run with a read and a write
// per touched word. The bitmap memory, with one write and one read port,
// serializes all of it.
// depends on cra_pkg, cra_in_if, cra_out_if, cra_map, cra_digit_scan
`timescale 1ns / 1ps
`default_nettype none

module contiguous_run_bitmap_allocator #(
  parameter int SECTOR_BYTES    = cra_pkg::SECTOR_BYTES_DEF,
  parameter int MAX_MAP_SECTORS = cra_pkg::MAX_MAP_SECTORS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  cra_in_if.sink                          in_ch,
  cra_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire cra_pkg::cfg_idx_t          cfg_index,
  input  wire logic [cra_pkg::FDS_W-1:0]  cfg_wdata
);

  localparam int WORDS_PER_SEC = SECTOR_BYTES / 4;
  localparam int MAP_WORDS     = MAX_MAP_SECTORS * WORDS_PER_SEC;
  localparam int AW            = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LW            = $clog2(MAP_WORDS + 1);
  localparam int BW            = AW + cra_pkg::WBIT_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  cra_pkg::state_t state_r, state_nxt;

  logic [cra_pkg::FDS_W-1:0]     fds_r;
  logic [cra_pkg::MSEC_W-1:0]    msec_r;

  logic [AW-1:0]                 clr_ptr_r;
  logic [AW-1:0]                 word_ptr_r;
  logic [cra_pkg::DIG_CNT_W-1:0] dig_r;
  logic [cra_pkg::COUNT_W-1:0]   attempt_r;
  logic [cra_pkg::COUNT_W-1:0]   want_r;
  logic [LW-1:0]                 limit_r;
  logic [BW-1:0]                 start_r;
  logic [BW-1:0]                 end_r;
  logic [AW-1:0]                 mark_ptr_r;

  logic                          res_ok_r;
  logic [cra_pkg::FSEC_W-1:0]    res_first_r;
  logic [cra_pkg::COUNT_W-1:0]   res_granted_r;
  logic                          res_fell_r;

  logic                          out_valid_r;
  logic                          out_ok_r;
  logic [cra_pkg::FSEC_W-1:0]    out_first_r;
  logic [cra_pkg::COUNT_W-1:0]   out_granted_r;
  logic                          out_fell_r;

  logic                          in_ready;
  logic                          accept;
  logic                          is_preset;
  logic                          idx_in_map;
  logic                          out_free;
  logic                          last_word;
  logic [7:0]                    secs_c;
  logic [LW-1:0]                 limit_c;
  logic [cra_pkg::COUNT_W-1:0]   want_c;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [cra_pkg::WORD_W-1:0]    mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [cra_pkg::WORD_W-1:0]    mem_rdata;
  logic [cra_pkg::WORD_W-1:0]    mark_mask;
  logic [cra_pkg::WBIT_W-1:0]    mask_lo;
  logic [cra_pkg::WBIT_W-1:0]    mask_hi;

  cra_pkg::scan_ctl_t            scan_ctl;
  logic                          hit;
  logic [BW-1:0]                 hit_start;
  logic [BW-1:0]                 scan_base;

  assign accept     = in_ch.valid && in_ready;
  assign is_preset  = (in_ch.req_type == cra_pkg::REQ_PRESET);
  assign idx_in_map = (32'(in_ch.word_index) < 32'(MAP_WORDS));
  assign out_free   = !out_valid_r || out_ch.ready;
  assign last_word  = ((LW'(word_ptr_r) + LW'(1)) == limit_r);
  assign want_c     = (in_ch.sector_count == '0) ? cra_pkg::COUNT_W'(1)
                                                 : in_ch.sector_count;
  assign secs_c     = (8'(msec_r) > 8'(MAX_MAP_SECTORS)) ? 8'(MAX_MAP_SECTORS)
                                                         : 8'(msec_r);
  assign limit_c    = LW'(32'(secs_c) * WORDS_PER_SEC);
  assign scan_base  = {word_ptr_r, dig_r, {cra_pkg::DIGIT_IW{1'b0}}};

  assign mask_lo   = (mark_ptr_r == start_r[BW-1:cra_pkg::WBIT_W])
                     ? start_r[cra_pkg::WBIT_W-1:0] : '0;
  assign mask_hi   = (mark_ptr_r == end_r[BW-1:cra_pkg::WBIT_W])
                     ? end_r[cra_pkg::WBIT_W-1:0] : '1;
  assign mark_mask = ({cra_pkg::WORD_W{1'b1}} << mask_lo)
                   & ({cra_pkg::WORD_W{1'b1}} >> (~mask_hi));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cra_pkg::S_CLEAR:   if (clr_ptr_r == LAST_WORD) state_nxt = cra_pkg::S_IDLE;
      cra_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = is_preset ? cra_pkg::S_RESP : cra_pkg::S_FETCH;
        end
      end
      cra_pkg::S_FETCH: begin
        state_nxt = (limit_r == '0) ? cra_pkg::S_RESP : cra_pkg::S_SCAN;
      end
      cra_pkg::S_SCAN: begin
        if (hit) begin
          state_nxt = cra_pkg::S_MARK_RD;
        end else if (dig_r == cra_pkg::DIG_LAST && last_word) begin
          state_nxt = (attempt_r == cra_pkg::COUNT_W'(1)) ? cra_pkg::S_RESP
                                                          : cra_pkg::S_FETCH;
        end
      end
      cra_pkg::S_MARK_RD: state_nxt = cra_pkg::S_MARK_WR;
      cra_pkg::S_MARK_WR: begin
        state_nxt = (mark_ptr_r == end_r[BW-1:cra_pkg::WBIT_W]) ? cra_pkg::S_RESP
                                                                : cra_pkg::S_MARK_RD;
      end
      cra_pkg::S_RESP:    if (out_free) state_nxt = cra_pkg::S_IDLE;
      default:            state_nxt = cra_pkg::S_CLEAR;
    endcase
  end

  // memory and scanner controls
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = word_ptr_r;
    mem_wdata = '0;
    mem_raddr = word_ptr_r;
    scan_ctl  = '0;
    unique case (state_r)
      cra_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_r;
      end
      cra_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        mem_we    = accept && is_preset && idx_in_map;
        mem_waddr = AW'(in_ch.word_index);
        mem_wdata = in_ch.word_value;
      end
      cra_pkg::S_FETCH: begin
        scan_ctl.clear = 1'b1;
      end
      cra_pkg::S_SCAN: begin
        mem_raddr         = word_ptr_r + AW'(1);
        scan_ctl.step     = 1'b1;
        scan_ctl.from_mem = (dig_r == '0);
      end
      cra_pkg::S_MARK_RD: begin
        mem_raddr = mark_ptr_r;
      end
      cra_pkg::S_MARK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mark_ptr_r;
        mem_wdata = mem_rdata | mark_mask;
      end
      cra_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cra_pkg::S_CLEAR;
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
      fds_r       <= '0;
      msec_r      <= cra_pkg::MSEC_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          cra_pkg::CFG_FIRST_DATA_SECTOR: fds_r  <= cfg_wdata;
          cra_pkg::CFG_MAP_SECTORS:       msec_r <= cfg_wdata[cra_pkg::MSEC_W-1:0];
          default: begin
          end
        endcase
      end

      if (state_r == cra_pkg::S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        cra_pkg::S_CLEAR: clr_ptr_r <= clr_ptr_r + AW'(1);
        cra_pkg::S_IDLE: begin
          if (accept) begin
            attempt_r     <= want_c;
            want_r        <= want_c;
            limit_r       <= limit_c;
            word_ptr_r    <= '0;
            dig_r         <= '0;
            res_ok_r      <= is_preset && idx_in_map;
            res_first_r   <= '0;
            res_granted_r <= '0;
            res_fell_r    <= 1'b0;
          end
        end
        cra_pkg::S_FETCH: dig_r <= '0;
        cra_pkg::S_SCAN: begin
          if (hit) begin
            start_r       <= hit_start;
            end_r         <= hit_start + BW'(attempt_r) - BW'(1);
            mark_ptr_r    <= hit_start[BW-1:cra_pkg::WBIT_W];
            res_ok_r      <= 1'b1;
            res_first_r   <= cra_pkg::FSEC_W'(fds_r) + cra_pkg::FSEC_W'(hit_start);
            res_granted_r <= attempt_r;
            res_fell_r    <= (attempt_r < want_r);
          end else if (dig_r == cra_pkg::DIG_LAST) begin
            dig_r <= '0;
            if (last_word) begin
              word_ptr_r <= '0;
              attempt_r  <= attempt_r >> 1;
            end else begin
              word_ptr_r <= word_ptr_r + AW'(1);
            end
          end else begin
            dig_r <= dig_r + cra_pkg::DIG_CNT_W'(1);
          end
        end
        cra_pkg::S_MARK_WR: mark_ptr_r <= mark_ptr_r + AW'(1);
        cra_pkg::S_RESP: begin
          if (out_free) begin
            out_ok_r      <= res_ok_r;
            out_first_r   <= res_first_r;
            out_granted_r <= res_granted_r;
            out_fell_r    <= res_fell_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.first_sector  = out_first_r;
  assign out_ch.granted_count = out_granted_r;
  assign out_ch.fell_back     = out_fell_r;

  cra_map #(
    .WORDS (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  cra_digit_scan #(
    .BW (BW)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .rdata     (mem_rdata),
    .base      (scan_base),
    .len       (attempt_r),
    .hit       (hit),
    .hit_start (hit_start)
  );

endmodule

`default_nettype wire
